FILE: design/pfe_pkg.sv
// Package for the palette fade engine: request and mode codes, the
// sequencer state type and the per-color step function.
// No dependencies.
package pfe_pkg;

  localparam int unsigned ColorW = 12;

  // request codes
  localparam logic [2:0] ReqWriteTarget  = 3'd0;
  localparam logic [2:0] ReqWriteCurrent = 3'd1;
  localparam logic [2:0] ReqFadeStep     = 3'd2;
  localparam logic [2:0] ReqReadCurrent  = 3'd3;
  localparam logic [2:0] ReqPreset       = 3'd4;

  // fade modes
  localparam logic [1:0] ModeFadeIn   = 2'd0;
  localparam logic [1:0] ModeFadeOut  = 2'd1;
  localparam logic [1:0] ModeWhiteIn  = 2'd2;
  localparam logic [1:0] ModeWhiteOut = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CfgFadeStart   = 2'd0;
  localparam logic [1:0] CfgFadeSize    = 2'd1;
  localparam logic [1:0] CfgFadeMode    = 2'd2;
  localparam logic [1:0] CfgWaterEnable = 2'd3;

  localparam logic [ColorW-1:0] ColorWhite = 12'hEEE;
  localparam logic [ColorW-1:0] ColorBlack = 12'h000;
  localparam logic [ColorW-1:0] RedBits    = 12'h00E;
  localparam logic [ColorW-1:0] GreenBits  = 12'h0E0;
  localparam logic [ColorW-1:0] BlueBits   = 12'hE00;
  localparam logic [ColorW-1:0] RedUnit    = 12'h002;
  localparam logic [ColorW-1:0] GreenUnit  = 12'h020;
  localparam logic [ColorW-1:0] BlueUnit   = 12'h200;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StFade,
    StFlush,
    StPreset,
    StResult
  } pfe_state_e;

  // One step of the selected fade mode for one entry.
  function automatic logic [ColorW-1:0] pfe_step(input logic [1:0] mode,
                                                 input logic [ColorW-1:0] cur,
                                                 input logic [ColorW-1:0] dst);
    logic [ColorW:0]   sum_b;
    logic [ColorW:0]   sum_g;
    logic [ColorW-1:0] res;
    sum_b = {1'b0, cur} + {1'b0, BlueUnit};
    sum_g = {1'b0, cur} + {1'b0, GreenUnit};
    res   = cur;
    case (mode)
      ModeFadeIn: begin
        if (cur != dst) begin
          if (sum_b <= {1'b0, dst})      res = sum_b[ColorW-1:0];
          else if (sum_g <= {1'b0, dst}) res = sum_g[ColorW-1:0];
          else                           res = cur + RedUnit;
        end
      end
      ModeFadeOut: begin
        if ((cur & RedBits) != '0)        res = cur - RedUnit;
        else if ((cur & GreenBits) != '0) res = cur - GreenUnit;
        else if ((cur & BlueBits) != '0)  res = cur - BlueUnit;
      end
      ModeWhiteIn: begin
        if (cur != dst) begin
          // component checked nonzero first, so the subtraction cannot wrap
          if (((cur & BlueBits) != '0) && ((cur - BlueUnit) >= dst))
            res = cur - BlueUnit;
          else if (((cur & GreenBits) != '0) && ((cur - GreenUnit) >= dst))
            res = cur - GreenUnit;
          else if ((cur & RedBits) != '0)
            res = cur - RedUnit;
        end
      end
      default: begin
        if (cur != ColorWhite) begin
          if ((cur & RedBits) != RedBits)          res = cur + RedUnit;
          else if ((cur & GreenBits) != GreenBits) res = cur + GreenUnit;
          else if ((cur & BlueBits) != BlueBits)   res = cur + BlueUnit;
        end
      end
    endcase
    return res;
  endfunction

endpackage

FILE: design/pfe_if.sv
// Handshake interfaces of the palette fade engine: request, response and
// configuration write channels. No dependencies.
interface pfe_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic        bank;
  logic [5:0]  index;
  logic [11:0] color;

  modport source (output valid, req_type, bank, index, color, input ready);
  modport sink   (input valid, req_type, bank, index, color, output ready);
endinterface

interface pfe_rsp_if;
  logic        valid;
  logic        ready;
  logic [11:0] read_color;
  logic        range_changed;

  modport source (output valid, read_color, range_changed, input ready);
  modport sink   (input valid, read_color, range_changed, output ready);
endinterface

interface pfe_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] addr;
  logic [6:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

FILE: design/palette_fade_engine_unit.sv
// Palette fade engine top level: palette memories, request sequencer,
// response register. Depends on pfe_pkg and the interfaces in pfe_if.sv.
//
// One request is handled at a time. A write or unknown request goes through
// the result state, a read of a valid index through the read and result
// states. A fade step streams the range through the current-color memory at
// one entry per cycle (read, step, write back), first on the dry bank and
// then, in fade-out, white-out or when water is enabled, in a water pass on
// the second bank; the range is clipped to the bank size. A preset writes one
// dry entry per cycle. The response sits in its own register, so the next
// request is taken while a response waits.
module palette_fade_engine_unit
  import pfe_pkg::*;
#(
  parameter int unsigned ENTRIES = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfe_req_if.sink   req_i,
  pfe_rsp_if.source rsp_o,
  pfe_cfg_if.sink   cfg_i
);

  localparam int unsigned Depth = 2 * ENTRIES;
  localparam int unsigned AW    = $clog2(Depth);
  localparam logic [8:0]  EntLim = 9'(ENTRIES);

  // configuration
  logic [5:0] fade_start_q;
  logic [6:0] fade_size_q;
  logic [1:0] fade_mode_q;
  logic       water_en_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_start_q <= '0;
      fade_size_q  <= 7'd64;
      fade_mode_q  <= ModeFadeIn;
      water_en_q   <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.addr)
        CfgFadeStart:   fade_start_q <= cfg_i.data[5:0];
        CfgFadeSize:    fade_size_q  <= cfg_i.data;
        CfgFadeMode:    fade_mode_q  <= cfg_i.data[1:0];
        CfgWaterEnable: water_en_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // range end, clipped to the bank size
  logic [8:0] range_sum;
  logic [8:0] range_end;
  assign range_sum = {3'b0, fade_start_q} + {2'b0, fade_size_q};
  assign range_end = (range_sum > EntLim) ? EntLim : range_sum;

  // sequencer state
  pfe_state_e state_q, state_d;
  logic [8:0]    ent_q, ent_d;
  logic [8:0]    end_q, end_d;
  logic          bank_q, bank_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] pend_addr_q, pend_addr_d;
  logic [11:0]   res_color_q, res_color_d;
  logic          res_chg_q, res_chg_d;
  logic          out_valid_q, out_valid_d;
  logic [11:0]   out_color_q, out_color_d;
  logic          out_chg_q, out_chg_d;

  // memories
  logic [11:0]   cur_mem [Depth];
  logic [11:0]   tgt_mem [Depth];
  logic [11:0]   cur_rdata_q;
  logic [11:0]   tgt_rdata_q;
  logic [AW-1:0] rd_addr;
  logic          cur_we;
  logic [AW-1:0] cur_waddr;
  logic [11:0]   cur_wdata;
  logic          tgt_we;

  // request decode
  logic       req_fire;
  logic       idx_ok;
  logic [8:0] req_addr9;
  assign req_i.ready = (state_q == StIdle);
  assign req_fire    = req_i.valid && req_i.ready;
  assign idx_ok      = ({3'b0, req_i.index} < EntLim);
  assign req_addr9   = req_i.bank ? (EntLim + {3'b0, req_i.index})
                                  : {3'b0, req_i.index};

  // fade walk
  logic       issue;
  logic       water_pass;
  logic [8:0] ent_addr9;
  assign issue      = (ent_q < end_q);
  assign water_pass = fade_mode_q[0] || water_en_q;
  assign ent_addr9  = bank_q ? (ent_q + EntLim) : ent_q;

  // write-back of the entry read in the previous cycle
  logic [11:0] step_color;
  logic        step_diff;
  assign step_color = pfe_step(fade_mode_q, cur_rdata_q, tgt_rdata_q);
  assign step_diff  = pend_q && (step_color != cur_rdata_q);

  logic out_free;
  assign out_free = !out_valid_q || rsp_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (req_fire) begin
          case (req_i.req_type)
            ReqFadeStep:    state_d = StFade;
            ReqPreset:      state_d = StPreset;
            ReqReadCurrent: state_d = idx_ok ? StRead : StResult;
            default:        state_d = StResult;
          endcase
        end
      end
      StRead: state_d = StResult;
      StFade: begin
        if (!issue && !(!bank_q && water_pass)) state_d = StFlush;
      end
      StFlush: state_d = StResult;
      StPreset: begin
        if (!issue) state_d = StResult;
      end
      StResult: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // datapath control
  always_comb begin
    ent_d       = ent_q;
    end_d       = end_q;
    bank_d      = bank_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    res_color_d = res_color_q;
    res_chg_d   = res_chg_q || step_diff;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_color_d = out_color_q;
    out_chg_d   = out_chg_q;
    rd_addr     = ent_addr9[AW-1:0];
    cur_we      = step_diff;
    cur_waddr   = pend_addr_q;
    cur_wdata   = step_color;
    tgt_we      = 1'b0;
    case (state_q)
      StIdle: begin
        rd_addr = req_addr9[AW-1:0];
        if (req_fire) begin
          res_color_d = '0;
          res_chg_d   = 1'b0;
          ent_d       = {3'b0, fade_start_q};
          end_d       = range_end;
          bank_d      = 1'b0;
          cur_waddr   = req_addr9[AW-1:0];
          cur_wdata   = req_i.color;
          cur_we      = idx_ok && (req_i.req_type == ReqWriteCurrent);
          tgt_we      = idx_ok && (req_i.req_type == ReqWriteTarget);
        end
      end
      StRead: res_color_d = cur_rdata_q;
      StFade: begin
        if (issue) begin
          pend_d      = 1'b1;
          pend_addr_d = ent_addr9[AW-1:0];
          ent_d       = ent_q + 9'd1;
        end else if (!bank_q && water_pass) begin
          bank_d = 1'b1;
          ent_d  = {3'b0, fade_start_q};
        end
      end
      StPreset: begin
        if (issue) begin
          cur_we    = 1'b1;
          cur_waddr = ent_q[AW-1:0];
          cur_wdata = fade_mode_q[1] ? ColorWhite : ColorBlack;
          ent_d     = ent_q + 9'd1;
        end
      end
      StResult: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_color_d = res_color_q;
          out_chg_d   = res_chg_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q       <= ent_d;
    end_q       <= end_d;
    bank_q      <= bank_d;
    pend_addr_q <= pend_addr_d;
    res_color_q <= res_color_d;
    res_chg_q   <= res_chg_d;
    out_color_q <= out_color_d;
    out_chg_q   <= out_chg_d;
  end

  // current colors: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cur_we) cur_mem[cur_waddr] <= cur_wdata;
    cur_rdata_q <= cur_mem[rd_addr];
  end

  // target colors
  always_ff @(posedge clk_i) begin
    if (tgt_we) tgt_mem[req_addr9[AW-1:0]] <= req_i.color;
    tgt_rdata_q <= tgt_mem[rd_addr];
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.read_color    = out_color_q;
  assign rsp_o.range_changed = out_chg_q;

endmodule
